### hdl/dar7seg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dar7seg_pkg: shared types, constants and the digit font
// Widths, ranging constants, reciprocal multipliers and the seven-segment
// encoding used by the distance autorange display block.
// ----------------------------------------------------------------------------
package dar7seg_pkg;

    localparam int DIST_W             = 20;
    localparam int DIG_REG_W          = 4;
    localparam int SEG_W              = 8;
    localparam int NUM_DIGITS         = 3;
    localparam int IDX_W              = 3;
    localparam int NUM_DIGIT_REGS_DEF = 8;

    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = 3;
    localparam int QCNT_W      = 4;

    localparam logic [DIST_W-1:0] DIST_MAX     = 20'd999999;
    localparam logic [DIST_W-1:0] METER_MAX    = 20'd999;
    localparam logic [DIST_W-1:0] KM_HUND_MAX  = 20'd9999;
    localparam logic [DIST_W-1:0] KM_TENTH_MAX = 20'd99999;

    // Division by 10, 100 and 1000 as a multiply by a scaled reciprocal.
    // The scale factors leave an error well below one unit of the quotient
    // over each range's span of inputs.
    localparam int RECIP_W = 21;
    localparam int PROD_W  = DIST_W + RECIP_W;
    localparam int VAL_W   = 10;

    localparam logic [RECIP_W-1:0] RECIP_ONE  = 21'd1048576;
    localparam logic [RECIP_W-1:0] RECIP_10   = 21'd104858;
    localparam logic [RECIP_W-1:0] RECIP_100  = 21'd167773;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 21'd1073742;

    localparam int SHIFT_20 = 20;
    localparam int SHIFT_24 = 24;
    localparam int SHIFT_30 = 30;

    // Digit split of a value below 1000.
    localparam int HMUL_W     = 16;
    localparam int HUND_RECIP = 41;
    localparam int HUND_SHIFT = 12;
    localparam int REM_W      = 7;
    localparam int TMUL_W     = 15;
    localparam int TEN_RECIP  = 205;
    localparam int TEN_SHIFT  = 11;
    localparam int DIGIT_W    = 4;

    localparam logic [SEG_W-1:0] DP_BIT = 8'b1000_0000;

    typedef enum logic [1:0] {
        RNG_M,
        RNG_KM_HUND,
        RNG_KM_TENTH,
        RNG_KM_UNIT
    } range_t;

    typedef logic [NUM_DIGITS-1:0][SEG_W-1:0] seg_bank_t;

    typedef struct packed {
        logic      valid;
        seg_bank_t seg;
    } front_item_t;

    typedef struct packed {
        logic      empty;
        seg_bank_t seg;
    } queue_head_t;

    function automatic logic [SEG_W-1:0] seg_font(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 8'b0111_1110;
            4'd1:    s = 8'b0011_0000;
            4'd2:    s = 8'b0110_1101;
            4'd3:    s = 8'b0111_1001;
            4'd4:    s = 8'b0011_0011;
            4'd5:    s = 8'b0101_1011;
            4'd6:    s = 8'b0101_1111;
            4'd7:    s = 8'b0111_0000;
            4'd8:    s = 8'b0111_1111;
            4'd9:    s = 8'b0111_1011;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

### hdl/distance_autorange_seven_segment_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// distance_autorange_seven_segment_top: distance to seven-segment writes
// Autoranges a distance in meters onto three digits and emits one display
// driver register write for each digit register.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request yields
// NUM_DIGIT_REGS writes on consecutive cycles, addresses 1 upward, each shown
// for one cycle with strobe high and last_frame marking the final one; the
// receiver cannot stall them. The first write comes out through, in order,
// the first ranging stage, which loads on the edge that takes the request,
// five more ranging and digit stages, the queue, the writer's digit-set
// register and the output register. Requests may come every cycle until up
// to eight are outstanding; the sustained rate is set by the writer, which
// emits one register write per cycle and NUM_DIGIT_REGS writes per request.
module distance_autorange_seven_segment_top
    import dar7seg_pkg::*;
#(
    parameter int NUM_DIGIT_REGS = NUM_DIGIT_REGS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [DIST_W-1:0]    distance_m,
    output logic                      strobe,
    output logic [DIG_REG_W-1:0]      digit_register,
    output logic [SEG_W-1:0]          segment_byte,
    output logic                      last_frame
);

    logic              accept;
    logic              pop;
    front_item_t       item;
    queue_head_t       head;
    logic [QCNT_W-1:0] pending_reg, pending_next;

    // Requests in the pipeline or queue; bounded by the queue depth so the
    // front never has to stall.
    assign busy   = (pending_reg == QCNT_W'(QUEUE_DEPTH));
    assign accept = start && !busy;

    always_comb
    begin
        pending_next = pending_reg + QCNT_W'(accept) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    dar7seg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .distance_m (distance_m),
        .item       (item)
    );

    dar7seg_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_item (item),
        .pop       (pop),
        .head      (head)
    );

    dar7seg_back #(
        .NUM_DIGIT_REGS (NUM_DIGIT_REGS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .pop            (pop),
        .strobe         (strobe),
        .digit_register (digit_register),
        .segment_byte   (segment_byte),
        .last_frame     (last_frame)
    );

endmodule
`default_nettype wire

### hdl/dar7seg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dar7seg_front: ranging and digit extraction pipeline
// Saturates and classifies each distance, scales it by a reciprocal multiply,
// splits the result into three digits and encodes them with decimal point.
// ----------------------------------------------------------------------------
module dar7seg_front
    import dar7seg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [DIST_W-1:0] distance_m,
    output front_item_t            item
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] vld_reg, vld_next;

    logic [DIST_W-1:0]  s1_d_reg;
    range_t             s1_rng_reg, s2_rng_reg, s3_rng_reg, s4_rng_reg, s5_rng_reg, s6_rng_reg;
    logic [PROD_W-1:0]  s2_prod_reg;
    logic [VAL_W-1:0]   s3_v_reg, s4_v_reg;
    logic [DIGIT_W-1:0] s4_h_reg, s5_h_reg, s6_h_reg, s6_t_reg;
    logic [REM_W-1:0]   s5_rem_reg, s6_rem_reg;

    logic [DIST_W-1:0]  d_sat;
    range_t             rng;
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod;
    logic [VAL_W-1:0]   v;
    logic [HMUL_W-1:0]  hmul;
    logic [VAL_W-1:0]   rem_full;
    logic [TMUL_W-1:0]  tmul;
    logic [REM_W-1:0]   units_full;
    logic [DIGIT_W-1:0] units;

    always_comb
    begin
        d_sat = (distance_m > DIST_MAX) ? DIST_MAX : distance_m;
        priority if (d_sat <= METER_MAX)
            rng = RNG_M;
        else if (d_sat <= KM_HUND_MAX)
            rng = RNG_KM_HUND;
        else if (d_sat <= KM_TENTH_MAX)
            rng = RNG_KM_TENTH;
        else
            rng = RNG_KM_UNIT;
    end

    always_comb
    begin
        unique case (s1_rng_reg)
            RNG_M:        recip = RECIP_ONE;
            RNG_KM_HUND:  recip = RECIP_10;
            RNG_KM_TENTH: recip = RECIP_100;
            RNG_KM_UNIT:  recip = RECIP_1000;
            default:      recip = RECIP_ONE;
        endcase
        prod = PROD_W'(s1_d_reg) * PROD_W'(recip);
    end

    always_comb
    begin
        unique case (s2_rng_reg)
            RNG_M:        v = VAL_W'(s2_prod_reg >> SHIFT_20);
            RNG_KM_HUND:  v = VAL_W'(s2_prod_reg >> SHIFT_20);
            RNG_KM_TENTH: v = VAL_W'(s2_prod_reg >> SHIFT_24);
            RNG_KM_UNIT:  v = VAL_W'(s2_prod_reg >> SHIFT_30);
            default:      v = '0;
        endcase
    end

    assign hmul       = HMUL_W'(s3_v_reg) * HMUL_W'(HUND_RECIP);
    assign rem_full   = s4_v_reg - VAL_W'(s4_h_reg) * VAL_W'(100);
    assign tmul       = TMUL_W'(s5_rem_reg) * TMUL_W'(TEN_RECIP);
    assign units_full = s6_rem_reg - REM_W'(s6_t_reg) * REM_W'(10);
    assign units      = units_full[DIGIT_W-1:0];

    assign vld_next = {vld_reg[STAGES-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_d_reg    <= d_sat;
        s1_rng_reg  <= rng;
        s2_prod_reg <= prod;
        s2_rng_reg  <= s1_rng_reg;
        s3_v_reg    <= v;
        s3_rng_reg  <= s2_rng_reg;
        s4_v_reg    <= s3_v_reg;
        s4_h_reg    <= DIGIT_W'(hmul >> HUND_SHIFT);
        s4_rng_reg  <= s3_rng_reg;
        s5_rem_reg  <= rem_full[REM_W-1:0];
        s5_h_reg    <= s4_h_reg;
        s5_rng_reg  <= s4_rng_reg;
        s6_rem_reg  <= s5_rem_reg;
        s6_t_reg    <= DIGIT_W'(tmul >> TEN_SHIFT);
        s6_h_reg    <= s5_h_reg;
        s6_rng_reg  <= s5_rng_reg;
    end

    always_comb
    begin
        item.valid  = vld_reg[STAGES-1];
        item.seg[0] = seg_font(s6_h_reg) | ((s6_rng_reg == RNG_KM_HUND) ? DP_BIT : '0);
        item.seg[1] = seg_font(s6_t_reg) | ((s6_rng_reg == RNG_KM_TENTH) ? DP_BIT : '0);
        item.seg[2] = seg_font(units) | ((s6_rng_reg == RNG_KM_UNIT) ? DP_BIT : '0);
    end

endmodule
`default_nettype wire

### hdl/dar7seg_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dar7seg_fifo: queue of encoded digit sets
// Holds finished digit sets between the ranging pipeline and the writer.
// ----------------------------------------------------------------------------
module dar7seg_fifo
    import dar7seg_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire front_item_t  push_item,
    input  wire logic         pop,
    output queue_head_t       head
);

    seg_bank_t         mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              do_pop;

    assign push   = push_item.valid;
    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item.seg;
        end
    end

    assign head.empty = (count_reg == '0);
    assign head.seg   = mem[rd_ptr_reg];

    // The top level's request credit must keep the queue from overflowing.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != QCNT_W'(QUEUE_DEPTH)))
        else $error("digit set pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop requested from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond its depth");

endmodule
`default_nettype wire

### hdl/dar7seg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dar7seg_back: display register writer
// Takes one digit set from the queue and emits one register write per
// digit register, one per cycle, moving straight on to a queued next set.
// ----------------------------------------------------------------------------
module dar7seg_back
    import dar7seg_pkg::*;
#(
    parameter int NUM_DIGIT_REGS = NUM_DIGIT_REGS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire queue_head_t          head,
    output logic                      pop,
    output logic                      strobe,
    output logic [DIG_REG_W-1:0]      digit_register,
    output logic [SEG_W-1:0]          segment_byte,
    output logic                      last_frame
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DIGIT_REGS - 1);

    logic                 active_reg, active_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    seg_bank_t            cur_reg, cur_next;
    logic                 strobe_reg, strobe_next;
    logic [DIG_REG_W-1:0] digit_register_reg, digit_register_next;
    logic [SEG_W-1:0]     segment_byte_reg, segment_byte_next;
    logic                 last_frame_reg, last_frame_next;
    logic                 at_last;

    assign at_last = active_reg && (idx_reg == LAST_IDX);
    assign pop     = (!active_reg || at_last) && !head.empty;

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        cur_next    = cur_reg;
        if (pop)
        begin
            active_next = 1'b1;
            idx_next    = '0;
            cur_next    = head.seg;
        end
        else if (at_last)
        begin
            active_next = 1'b0;
        end
        else if (active_reg)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end

        strobe_next         = active_reg;
        digit_register_next = DIG_REG_W'(idx_reg) + DIG_REG_W'(1);
        last_frame_next     = at_last;
        if (idx_reg < IDX_W'(NUM_DIGITS))
            segment_byte_next = cur_reg[idx_reg[1:0]];
        else
            segment_byte_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg            <= cur_next;
        digit_register_reg <= digit_register_next;
        segment_byte_reg   <= segment_byte_next;
        last_frame_reg     <= last_frame_next;
    end

    assign strobe         = strobe_reg;
    assign digit_register = digit_register_reg;
    assign segment_byte   = segment_byte_reg;
    assign last_frame     = last_frame_reg;

    // Within a run the register addresses climb by one with no gap.
    a_run_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_frame |=>
            strobe && (digit_register == $past(digit_register) + DIG_REG_W'(1)))
        else $error("register write run broken or out of order");

    a_last_address: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_frame |-> (digit_register == DIG_REG_W'(NUM_DIGIT_REGS)))
        else $error("final write not on the last digit register");

    a_blank_unused: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (digit_register > DIG_REG_W'(NUM_DIGITS)) |-> (segment_byte == '0))
        else $error("unused digit register written with segments lit");

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the distance autorange seven-segment block
// Sends distances through the start/busy handshake and predicts, for each
// request, the eight display register writes it must cause. Every strobed
// write is checked field by field against the oldest write still due.
// ----------------------------------------------------------------------------
module tb_top;
    import dar7seg_pkg::*;

    localparam int  NUM_REGS       = NUM_DIGIT_REGS_DEF;
    localparam int  RANDOM_ITEMS   = 360;
    localparam int  QUIET_FIRST    = 120;
    localparam int  QUIET_LAST     = 220;
    localparam int  SETTLE_CYCLES  = 16;
    localparam int  CYCLE_LIMIT    = 200000;

    // Segment patterns for 0..9, pABCDEFG with the point clear.
    localparam logic [SEG_W-1:0] GLYPH [10] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
    };
    localparam logic [SEG_W-1:0] POINT = 8'h80;

    typedef struct {
        logic [DIST_W-1:0] meters;
        logic              drain_first;
    } distance_request_t;

    typedef struct {
        logic [DIG_REG_W-1:0] addr;
        logic [SEG_W-1:0]     seg;
        logic                 last;
    } register_write_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [DIST_W-1:0]    distance_m = '0;
    logic                 busy;
    logic                 strobe;
    logic [DIG_REG_W-1:0] digit_register;
    logic [SEG_W-1:0]     segment_byte;
    logic                 last_frame;

    distance_request_t distance_requests[$];
    register_write_t   writes_due[$];
    int                total_requests = 0;
    int                sent_count = 0;
    int                taken_count = 0;
    int                error_count = 0;
    int                cycle_count = 0;

    distance_autorange_seven_segment_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .distance_m     (distance_m),
        .strobe         (strobe),
        .digit_register (digit_register),
        .segment_byte   (segment_byte),
        .last_frame     (last_frame)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Ranges the distance onto three digits and queues the register writes.
    function automatic void predict_display_writes(input logic [DIST_W-1:0] meters_in);
        logic [DIST_W-1:0] d;
        int unsigned       shown;
        range_t            rng;
        logic [SEG_W-1:0]  digit_segs [3];
        register_write_t   w;
        d = (meters_in > DIST_MAX) ? DIST_MAX : meters_in;
        if (d > METER_MAX && d <= KM_HUND_MAX)
        begin
            shown = d / 10;
            rng = RNG_KM_HUND;
        end
        else if (d > KM_HUND_MAX && d <= KM_TENTH_MAX)
        begin
            shown = d / 100;
            rng = RNG_KM_TENTH;
        end
        else if (d > KM_TENTH_MAX)
        begin
            shown = d / 1000;
            rng = RNG_KM_UNIT;
        end
        else
        begin
            shown = d;
            rng = RNG_M;
        end
        digit_segs[0] = GLYPH[shown / 100] | ((rng == RNG_KM_HUND) ? POINT : '0);
        digit_segs[1] = GLYPH[(shown % 100) / 10] | ((rng == RNG_KM_TENTH) ? POINT : '0);
        digit_segs[2] = GLYPH[shown % 10] | ((rng == RNG_KM_UNIT) ? POINT : '0);
        for (int r = 0; r < NUM_REGS; r++)
        begin
            w.addr = DIG_REG_W'(r + 1);
            w.seg  = (r < 3) ? digit_segs[r] : '0;
            w.last = (r == NUM_REGS - 1);
            writes_due.push_back(w);
        end
    endfunction

    function automatic logic [DIST_W-1:0] random_distance();
        case ($urandom_range(0, 5))
            0: return DIST_W'($urandom_range(0, 999));
            1: return DIST_W'($urandom_range(1000, 9999));
            2: return DIST_W'($urandom_range(10000, 99999));
            3: return DIST_W'($urandom_range(100000, 999999));
            4: return DIST_W'($urandom_range(1000000, 1048575));
            default: return DIST_W'($urandom);
        endcase
    endfunction

    // Driver: holds a request until it is taken, then presents the next one.
    always @(posedge clk or negedge rst_n)
    begin
        logic              free;
        logic              idle;
        distance_request_t nxt;
        if (!rst_n)
        begin
            start      <= 1'b0;
            distance_m <= '0;
        end
        else
        begin
            free = !start;
            if (start && !busy)
            begin
                predict_display_writes(distance_m);
                taken_count++;
                free = 1'b1;
            end
            if (free)
            begin
                idle = ($urandom_range(0, 99) < 9)
                       && !(sent_count >= QUIET_FIRST && sent_count < QUIET_LAST);
                if (distance_requests.size() != 0 && !idle
                    && (!distance_requests[0].drain_first || writes_due.size() == 0))
                begin
                    nxt = distance_requests.pop_front();
                    start      <= 1'b1;
                    distance_m <= nxt.meters;
                    sent_count++;
                end
                else
                begin
                    start      <= 1'b0;
                    distance_m <= DIST_W'($urandom);
                end
            end
        end
    end

    // Monitor: every strobed write must match the oldest write still due.
    always @(posedge clk)
    begin
        register_write_t want;
        if (rst_n && strobe)
        begin
            if (writes_due.size() == 0)
            begin
                $error("unexpected write: digit_register %0d segment_byte 0x%02h last_frame %0b",
                       digit_register, segment_byte, last_frame);
                error_count++;
            end
            else
            begin
                want = writes_due.pop_front();
                if (digit_register !== want.addr)
                begin
                    $error("digit_register: expected %0d, got %0d", want.addr, digit_register);
                    error_count++;
                end
                if (segment_byte !== want.seg)
                begin
                    $error("segment_byte: expected 0x%02h, got 0x%02h", want.seg, segment_byte);
                    error_count++;
                end
                if (last_frame !== want.last)
                begin
                    $error("last_frame: expected %0b, got %0b", want.last, last_frame);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [DIST_W-1:0] directed [] = '{
            20'd0, 20'd1, 20'd9, 20'd99, 20'd100, 20'd555, 20'd999,
            20'd1000, 20'd1009, 20'd2345, 20'd9999,
            20'd10000, 20'd10099, 20'd67890, 20'd99999,
            20'd100000, 20'd100999, 20'd480123, 20'd888888, 20'd999999,
            20'd1000000, 20'hFFFFF
        };
        distance_request_t req;
        foreach (directed[i])
        begin
            req.meters      = directed[i];
            req.drain_first = 1'b0;
            distance_requests.push_back(req);
        end
        // The random part starts, and resumes at item 200 and at about one item in
        // fifty, only after the display writes of everything before have all come out.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            req.meters      = random_distance();
            req.drain_first = (i == 0) || (i == 200) || ($urandom_range(0, 49) == 0);
            distance_requests.push_back(req);
        end
        total_requests = distance_requests.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (taken_count < total_requests)
            @(posedge clk);
        while (writes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
